// ===== src/ppwa_pkg.sv =====
// ----------------------------------------------------------------------------
// ppwa_pkg
// Types and constants shared by the packed pixel write address pipeline.
// ----------------------------------------------------------------------------
package ppwa_pkg;

  localparam int unsigned XW       = 11;
  localparam int unsigned YW       = 11;
  localparam int unsigned ColourW  = 32;
  localparam int unsigned AddrW    = 32;
  localparam int unsigned WidthW   = 12;
  localparam int unsigned StrideW  = WidthW + 2;
  localparam int unsigned OffW     = XW + 2;
  localparam int unsigned ProdW    = YW + StrideW;
  localparam int unsigned InTdataW  = 56;
  localparam int unsigned OutTdataW = 80;

  localparam logic [WidthW-1:0] MaxWidth   = 12'd2048;
  localparam logic [WidthW-1:0] WidthReset = 12'd640;

  typedef enum logic [2:0] {
    DEPTH_1BPP  = 3'd0,
    DEPTH_4BPP  = 3'd1,
    DEPTH_8BPP  = 3'd2,
    DEPTH_16BPP = 3'd3,
    DEPTH_32BPP = 3'd4
  } depth_e;

  typedef enum logic [1:0] {
    CFG_FRAME_BASE   = 2'd0,
    CFG_SCREEN_WIDTH = 2'd1,
    CFG_DEPTH_MODE   = 2'd2
  } cfg_index_e;

  typedef enum logic [1:0] {
    SIZE_BYTE = 2'd0,
    SIZE_HALF = 2'd1,
    SIZE_WORD = 2'd2
  } access_size_e;

  typedef struct packed {
    logic [XW-1:0]      pixel_x;
    logic [YW-1:0]      pixel_y;
    logic [ColourW-1:0] colour;
  } pixel_t;

  typedef struct packed {
    logic [YW-1:0]      pixel_y;
    logic [StrideW-1:0] stride;
    logic [OffW-1:0]    offset;
    logic [1:0]         access_size;
    logic [31:0]        write_data;
    logic [7:0]         bit_mask;
  } decode_t;

  typedef struct packed {
    logic [ProdW-1:0] row_offset;
    logic [OffW-1:0]  offset;
    logic [1:0]       access_size;
    logic [31:0]      write_data;
    logic [7:0]       bit_mask;
  } product_t;

  typedef struct packed {
    logic [AddrW-1:0] byte_address;
    logic [1:0]       access_size;
    logic [31:0]      write_data;
    logic [7:0]       bit_mask;
  } write_t;

endpackage

// ===== src/ppwa_decode.sv =====
// ----------------------------------------------------------------------------
// ppwa_decode
// First stage: row stride, byte offset, access size, data and mask by depth.
// ----------------------------------------------------------------------------
module ppwa_decode
  import ppwa_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic [WidthW-1:0]  screen_width_i,
  input  logic [2:0]         depth_mode_i,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  pixel_t             in_pixel_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output decode_t            out_decode_o
);

  logic              valid_q, valid_d;
  decode_t           decode_q, decode_d;
  logic              keep;
  logic [WidthW-1:0] width_sat;
  logic [7:0]        pix_bit;

  assign in_ready_o = !valid_q || out_ready_i;
  assign width_sat  = (screen_width_i > MaxWidth) ? MaxWidth : screen_width_i;
  assign pix_bit    = 8'h80 >> in_pixel_i.pixel_x[2:0];

  always_comb begin
    keep                 = 1'b1;
    decode_d.pixel_y     = in_pixel_i.pixel_y;
    decode_d.stride      = StrideW'(width_sat);
    decode_d.offset      = OffW'(in_pixel_i.pixel_x);
    decode_d.access_size = SIZE_BYTE;
    decode_d.write_data  = {24'd0, in_pixel_i.colour[7:0]};
    decode_d.bit_mask    = 8'hff;
    case (depth_e'(depth_mode_i))
      DEPTH_1BPP: begin
        decode_d.stride     = StrideW'(width_sat >> 3);
        decode_d.offset     = OffW'(in_pixel_i.pixel_x >> 3);
        decode_d.bit_mask   = pix_bit;
        decode_d.write_data = (in_pixel_i.colour != '0) ? {24'd0, pix_bit} : 32'd0;
      end
      DEPTH_4BPP: begin
        decode_d.stride = StrideW'(width_sat >> 1);
        decode_d.offset = OffW'(in_pixel_i.pixel_x >> 1);
        if (in_pixel_i.pixel_x[0]) begin
          decode_d.bit_mask   = 8'h0f;
          decode_d.write_data = {28'd0, in_pixel_i.colour[3:0]};
        end else begin
          decode_d.bit_mask   = 8'hf0;
          decode_d.write_data = {24'd0, in_pixel_i.colour[3:0], 4'd0};
        end
      end
      DEPTH_8BPP: begin
      end
      DEPTH_16BPP: begin
        decode_d.stride      = {1'b0, width_sat, 1'b0};
        decode_d.offset      = {1'b0, in_pixel_i.pixel_x, 1'b0};
        decode_d.access_size = SIZE_HALF;
        decode_d.write_data  = {16'd0, in_pixel_i.colour[15:0]};
      end
      DEPTH_32BPP: begin
        decode_d.stride      = {width_sat, 2'b00};
        decode_d.offset      = {in_pixel_i.pixel_x, 2'b00};
        decode_d.access_size = SIZE_WORD;
        decode_d.write_data  = in_pixel_i.colour;
      end
      default: begin
        keep = 1'b0;
      end
    endcase
  end

  // Pixels in an unused depth mode are taken and dropped here.
  assign valid_d = in_ready_o ? (in_valid_i && keep) : valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      decode_q <= decode_d;
    end
  end

  assign out_valid_o  = valid_q;
  assign out_decode_o = decode_q;

endmodule

// ===== src/ppwa_mult.sv =====
// ----------------------------------------------------------------------------
// ppwa_mult
// Second stage: row number times row stride.
// ----------------------------------------------------------------------------
module ppwa_mult
  import ppwa_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_ready_o,
  input  decode_t  in_decode_i,
  output logic     out_valid_o,
  input  logic     out_ready_i,
  output product_t out_product_o
);

  logic     valid_q, valid_d;
  product_t product_q, product_d;

  assign in_ready_o = !valid_q || out_ready_i;
  assign valid_d    = in_ready_o ? in_valid_i : valid_q;

  always_comb begin
    product_d.row_offset  = ProdW'(in_decode_i.pixel_y) * ProdW'(in_decode_i.stride);
    product_d.offset      = in_decode_i.offset;
    product_d.access_size = in_decode_i.access_size;
    product_d.write_data  = in_decode_i.write_data;
    product_d.bit_mask    = in_decode_i.bit_mask;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      product_q <= product_d;
    end
  end

  assign out_valid_o   = valid_q;
  assign out_product_o = product_q;

endmodule

// ===== src/ppwa_addr.sv =====
// ----------------------------------------------------------------------------
// ppwa_addr
// Third stage: adds base, row offset and byte offset into the output register.
// ----------------------------------------------------------------------------
module ppwa_addr
  import ppwa_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic [AddrW-1:0] frame_base_i,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  product_t         in_product_i,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output write_t           out_write_o
);

  logic   valid_q, valid_d;
  write_t write_q, write_d;

  assign in_ready_o = !valid_q || out_ready_i;
  assign valid_d    = in_ready_o ? in_valid_i : valid_q;

  always_comb begin
    write_d.byte_address = frame_base_i + AddrW'(in_product_i.row_offset)
                         + AddrW'(in_product_i.offset);
    write_d.access_size  = in_product_i.access_size;
    write_d.write_data   = in_product_i.write_data;
    write_d.bit_mask     = in_product_i.bit_mask;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      write_q <= write_d;
    end
  end

  assign out_valid_o = valid_q;
  assign out_write_o = write_q;

endmodule

// ===== src/packed_pixel_write_address_top.sv =====
// ----------------------------------------------------------------------------
// packed_pixel_write_address_top
// Turns a pixel coordinate and colour into one framebuffer write.
//
// Channel   Direction  Contents
// s_axis    in         pixel transaction: x, y, colour
// m_axis    out        write transaction: address, size, data, bit mask
// cfg       in         register write: frame base, screen width, depth mode
//
// One pixel per cycle is accepted while m_axis is not stalled.
// The three stages are decode, stride multiply and address add.
// Reset clears the stage valid bits and loads the register reset values.
// A stall on m_axis backs up stage by stage without losing a transaction.
// Pixels in an unused depth mode are accepted and produce no write.
// ----------------------------------------------------------------------------
module packed_pixel_write_address_top
  import ppwa_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [1:0]           cfg_index_i,
  input  logic [31:0]          cfg_wdata_i,
  input  logic                 s_axis_tvalid,
  output logic                 s_axis_tready,
  // pixel_x[10:0], pixel_y[21:11], colour[53:22], zero pad
  input  logic [InTdataW-1:0]  s_axis_tdata,
  output logic                 m_axis_tvalid,
  input  logic                 m_axis_tready,
  // byte_address[31:0], access_size[33:32], write_data[65:34], bit_mask[73:66]
  output logic [OutTdataW-1:0] m_axis_tdata
);

  logic [AddrW-1:0]  frame_base_q;
  logic [WidthW-1:0] screen_width_q;
  logic [2:0]        depth_mode_q;

  pixel_t   pixel;
  decode_t  decode;
  product_t product;
  write_t   write_out;
  logic     dec_valid, dec_ready;
  logic     mul_valid, mul_ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frame_base_q   <= '0;
      screen_width_q <= WidthReset;
      depth_mode_q   <= DEPTH_32BPP;
    end else if (cfg_we_i) begin
      case (cfg_index_e'(cfg_index_i))
        CFG_FRAME_BASE:   frame_base_q   <= cfg_wdata_i;
        CFG_SCREEN_WIDTH: screen_width_q <= cfg_wdata_i[WidthW-1:0];
        CFG_DEPTH_MODE:   depth_mode_q   <= cfg_wdata_i[2:0];
        default: begin
        end
      endcase
    end
  end

  assign pixel.pixel_x = s_axis_tdata[10:0];
  assign pixel.pixel_y = s_axis_tdata[21:11];
  assign pixel.colour  = s_axis_tdata[53:22];

  ppwa_decode u_decode (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .screen_width_i (screen_width_q),
    .depth_mode_i   (depth_mode_q),
    .in_valid_i     (s_axis_tvalid),
    .in_ready_o     (s_axis_tready),
    .in_pixel_i     (pixel),
    .out_valid_o    (dec_valid),
    .out_ready_i    (dec_ready),
    .out_decode_o   (decode)
  );

  ppwa_mult u_mult (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (dec_valid),
    .in_ready_o    (dec_ready),
    .in_decode_i   (decode),
    .out_valid_o   (mul_valid),
    .out_ready_i   (mul_ready),
    .out_product_o (product)
  );

  ppwa_addr u_addr (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .frame_base_i (frame_base_q),
    .in_valid_i   (mul_valid),
    .in_ready_o   (mul_ready),
    .in_product_i (product),
    .out_valid_o  (m_axis_tvalid),
    .out_ready_i  (m_axis_tready),
    .out_write_o  (write_out)
  );

  assign m_axis_tdata = {6'd0, write_out.bit_mask, write_out.write_data,
                         write_out.access_size, write_out.byte_address};

endmodule

// ===== dv/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top
// Self-checking testbench for packed_pixel_write_address_top. Pixel
// transactions are streamed in under several register settings. A
// scoreboard predicts each framebuffer write from its own copy of the
// registers and compares every write that comes out. Both stream sides
// idle at random, and the write side is held off once for a long stretch.
// ----------------------------------------------------------------------------
module tb_top
  import ppwa_pkg::*;
();

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned CycleLimit  = 100000;
  localparam int unsigned DrainLimit  = 2000;
  localparam int unsigned SettleGap   = 8;
  localparam int unsigned HoldCycles  = 300;
  localparam int unsigned IdlePercent = 26;
  localparam int unsigned RandomItems = 530;
  localparam int unsigned PhaseItems  = 53;
  localparam int unsigned MaxReported = 10;

  localparam logic [1:0] CfgUnusedIndex = 2'd3;
  localparam logic [2:0] DepthSpareLo   = 3'd5;
  localparam logic [2:0] DepthSpareHi   = 3'd7;

  typedef struct {
    logic [31:0]  byte_address;
    access_size_e access_size;
    logic [31:0]  write_data;
    logic [7:0]   bit_mask;
  } fb_write_t;

  class pixel_write_scoreboard;
    logic [31:0] frame_base;
    logic [11:0] screen_width;
    logic [2:0]  depth_mode;
    fb_write_t   expected_writes[$];
    int unsigned failures;

    function new();
      frame_base   = '0;
      screen_width = WidthReset;
      depth_mode   = DEPTH_32BPP;
      failures     = 0;
    endfunction

    function void set_register(logic [1:0] index, logic [31:0] value);
      case (index)
        CFG_FRAME_BASE:   frame_base = value;
        CFG_SCREEN_WIDTH: screen_width = value[11:0];
        CFG_DEPTH_MODE:   depth_mode = value[2:0];
        default: ;
      endcase
    endfunction

    function int unsigned pending();
      return expected_writes.size();
    endfunction

    function void note_pixel(logic [10:0] x, logic [10:0] y, logic [31:0] colour);
      logic [31:0] row_width;
      logic [31:0] stride;
      logic [31:0] offset;
      fb_write_t   wr;
      row_width      = (screen_width > MaxWidth) ? 32'(MaxWidth) : 32'(screen_width);
      wr.bit_mask    = 8'hFF;
      wr.write_data  = colour;
      wr.access_size = SIZE_BYTE;
      case (depth_mode)
        DEPTH_1BPP: begin
          stride        = row_width >> 3;
          offset        = 32'(x) >> 3;
          wr.bit_mask   = 8'h80 >> x[2:0];
          wr.write_data = (colour != 0) ? {24'b0, wr.bit_mask} : 32'b0;
        end
        DEPTH_4BPP: begin
          stride = row_width >> 1;
          offset = 32'(x) >> 1;
          if (x[0]) begin
            wr.bit_mask   = 8'h0F;
            wr.write_data = {28'b0, colour[3:0]};
          end else begin
            wr.bit_mask   = 8'hF0;
            wr.write_data = {24'b0, colour[3:0], 4'b0};
          end
        end
        DEPTH_8BPP: begin
          stride        = row_width;
          offset        = 32'(x);
          wr.write_data = {24'b0, colour[7:0]};
        end
        DEPTH_16BPP: begin
          stride         = row_width * 2;
          offset         = 32'(x) * 2;
          wr.write_data  = {16'b0, colour[15:0]};
          wr.access_size = SIZE_HALF;
        end
        DEPTH_32BPP: begin
          stride         = row_width * 4;
          offset         = 32'(x) * 4;
          wr.access_size = SIZE_WORD;
        end
        default: return;
      endcase
      wr.byte_address = frame_base + 32'(y) * stride + offset;
      expected_writes.push_back(wr);
    endfunction

    function void mismatch(string field, logic [31:0] exp_v, logic [31:0] act_v);
      failures++;
      if (failures <= MaxReported) begin
        $display("%0t: %s mismatch, expected 0x%08h, got 0x%08h", $time, field, exp_v,
                 act_v);
      end
    endfunction

    function void check_write(logic [OutTdataW-1:0] tdata);
      fb_write_t wr;
      if (expected_writes.size() == 0) begin
        failures++;
        if (failures <= MaxReported) begin
          $display("%0t: unexpected write transaction 0x%020h", $time, tdata);
        end
        return;
      end
      wr = expected_writes.pop_front();
      if (tdata[31:0] != wr.byte_address) mismatch("byte_address", wr.byte_address,
                                                   tdata[31:0]);
      if (tdata[33:32] != wr.access_size) mismatch("access_size", 32'(wr.access_size),
                                                   32'(tdata[33:32]));
      if (tdata[65:34] != wr.write_data) mismatch("write_data", wr.write_data,
                                                  tdata[65:34]);
      if (tdata[73:66] != wr.bit_mask) mismatch("bit_mask", 32'(wr.bit_mask),
                                                32'(tdata[73:66]));
    endfunction
  endclass

  logic                 clk_i;
  logic                 rst_ni;
  logic                 cfg_we_i;
  logic [1:0]           cfg_index_i;
  logic [31:0]          cfg_wdata_i;
  logic                 s_axis_tvalid;
  logic                 s_axis_tready;
  logic [InTdataW-1:0]  s_axis_tdata;
  logic                 m_axis_tvalid;
  logic                 m_axis_tready;
  logic [OutTdataW-1:0] m_axis_tdata;

  pixel_write_scoreboard sb;
  bit                    quiet;
  bit                    hold_request;
  int unsigned           hold_left;
  int unsigned           cycle_count;

  packed_pixel_write_address_top i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_index_i   (cfg_index_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  always begin
    clk_i = 1'b0;
    #4;
    clk_i = 1'b1;
    #4;
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("tb_top NOT OK");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    if (hold_request) begin
      hold_request = 1'b0;
      hold_left    = HoldCycles;
    end
    if (hold_left != 0) begin
      hold_left--;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= quiet || ($urandom_range(99) >= IdlePercent);
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      sb.check_write(m_axis_tdata);
    end
  end

  task automatic send_pixel(logic [10:0] x, logic [10:0] y, logic [31:0] colour);
    while (!quiet && $urandom_range(99) < IdlePercent) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {2'b0, colour, y, x};
    do @(posedge clk_i); while (!s_axis_tready);
    sb.note_pixel(x, y, colour);
  endtask

  task automatic wait_idle();
    int unsigned waited;
    waited = 0;
    s_axis_tvalid <= 1'b0;
    while (sb.pending() != 0 && waited < DrainLimit) begin
      @(posedge clk_i);
      waited++;
    end
    repeat (SettleGap) @(posedge clk_i);
  endtask

  task automatic write_register(logic [1:0] index, logic [31:0] value);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= index;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    sb.set_register(index, value);
  endtask

  task automatic write_config(logic [31:0] base, logic [11:0] width, logic [2:0] depth,
                              bit garble);
    logic [31:0] upper;
    wait_idle();
    upper = garble ? $urandom : 32'b0;
    write_register(CFG_FRAME_BASE, base);
    write_register(CFG_SCREEN_WIDTH, {upper[31:12], width});
    write_register(CFG_DEPTH_MODE, {upper[31:3], depth});
    write_register(CfgUnusedIndex, $urandom);
    cfg_we_i <= 1'b0;
  endtask

  function automatic logic [31:0] pick_colour();
    case ($urandom_range(3))
      0:       return 32'b0;
      1:       return 32'($urandom_range(15));
      default: return $urandom;
    endcase
  endfunction

  initial begin
    logic [31:0] base;
    logic [11:0] width;
    logic [2:0]  depth;
    int unsigned counted;
    int unsigned phase;
    int unsigned items;

    sb            = new();
    quiet         = 1'b0;
    hold_request  = 1'b0;
    hold_left     = 0;
    cycle_count   = 0;
    rst_ni        <= 1'b0;
    cfg_we_i      <= 1'b0;
    cfg_index_i   <= CFG_FRAME_BASE;
    cfg_wdata_i   <= '0;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata  <= '0;
    m_axis_tready <= 1'b0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    send_pixel(11'd0, 11'd0, 32'h0);
    send_pixel(11'd2047, 11'd2047, 32'hFFFF_FFFF);
    write_config(32'hFFFF_FFF0, 12'd8, DEPTH_1BPP, 1'b0);
    send_pixel(11'd0, 11'd0, 32'h0);
    send_pixel(11'd7, 11'd0, 32'h1);
    send_pixel(11'd2047, 11'd2047, 32'h8000_0000);
    write_config(32'h1234_5678, 12'hFFF, DEPTH_4BPP, 1'b1);
    send_pixel(11'd0, 11'd0, 32'hF);
    send_pixel(11'd1, 11'd2047, 32'hFFFF_FFF5);
    send_pixel(11'd2047, 11'd2047, 32'h0);
    write_config(32'hFFFF_FFFF, 12'd2048, DEPTH_8BPP, 1'b0);
    send_pixel(11'd0, 11'd0, 32'h1FF);
    send_pixel(11'd2047, 11'd2047, 32'hFFFF_FFFF);
    write_config(32'h0, 12'd0, DEPTH_16BPP, 1'b0);
    send_pixel(11'd5, 11'd7, 32'hABCD_1234);
    send_pixel(11'd2047, 11'd2047, 32'hFFFF_FFFF);
    write_config(32'hFFFF_0000, 12'd2048, DEPTH_32BPP, 1'b1);
    send_pixel(11'd2047, 11'd2047, 32'hFFFF_FFFF);
    send_pixel(11'd1, 11'd1, 32'h0);
    write_config(32'h0000_1000, 12'd13, DEPTH_1BPP, 1'b0);
    send_pixel(11'd9, 11'd3, 32'h5);
    send_pixel(11'd2047, 11'd1, 32'h0);
    write_config(32'h5555_AAAA, 12'd641, DEPTH_4BPP, 1'b0);
    send_pixel(11'd640, 11'd2, 32'h7);
    write_config(32'h0, 12'd640, DepthSpareLo, 1'b0);
    send_pixel(11'd1, 11'd1, 32'h1);
    write_config(32'h0, 12'd640, DepthSpareHi, 1'b1);
    send_pixel(11'd2047, 11'd2047, 32'hFFFF_FFFF);

    counted = 0;
    phase   = 0;
    while (counted < RandomItems) begin
      if (phase < 5) depth = 3'(phase);
      else if (phase == 5) depth = 3'($urandom_range(DepthSpareHi, DepthSpareLo));
      else depth = 3'($urandom_range(DEPTH_32BPP));
      if (depth < DEPTH_8BPP && $urandom_range(3) != 0) width = 12'(8 * $urandom_range(256, 1));
      else width = 12'($urandom_range(4095));
      case ($urandom_range(3))
        0:       base = 32'h0;
        1:       base = 32'hFFFF_FFFF;
        default: base = $urandom;
      endcase
      write_config(base, width, depth, 1'($urandom_range(1)));
      quiet = (phase == 2);
      if (phase == 3) hold_request = 1'b1;
      items = (phase == 5) ? 16 : PhaseItems;
      repeat (items) begin
        send_pixel(11'($urandom_range(2047)), 11'($urandom_range(2047)), pick_colour());
        if (depth <= DEPTH_32BPP) counted++;
      end
      phase++;
    end

    quiet = 1'b0;
    wait_idle();
    sb.failures += sb.pending();
    if (sb.failures == 0) begin
      $display("tb_top OK");
    end else begin
      $display("tb_top NOT OK");
    end
    $finish;
  end

endmodule
